/* rtl/cl4_pkg.sv */
// Package for the character LCD 4-bit write sequencer.
// Request codes, decoded request and pin-state word types, fixed constants.
// No dependencies.
package cl4_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_nibble;
    typedef logic [4:0] t_units;
    typedef logic [2:0] t_step;

    localparam t_cmd CMD_INSTR      = 2'd0;
    localparam t_cmd CMD_DATA       = 2'd1;
    localparam t_cmd CMD_FIRST_NIB  = 2'd2;
    localparam t_cmd CMD_SET_CURSOR = 2'd3;

    localparam logic [1:0] ROW_LOWER = 2'd0;
    localparam logic [1:0] ROW_UPPER = 2'd1;

    localparam t_byte   DDRAM_UPPER_BASE  = 8'h80;
    localparam t_byte   DDRAM_LOWER_BASE  = 8'hC0;
    localparam t_nibble COLUMN_LIMIT      = 4'd8;
    localparam t_units  FIRST_PULSE_RESET = 5'd20;
    localparam t_units  HOLD_ONE          = 5'd1;
    localparam t_units  HOLD_ZERO         = 5'd0;

    // Step indexes inside one request
    localparam t_step STEP_OLD     = 3'd0;
    localparam t_step STEP_HI_SET  = 3'd1;
    localparam t_step STEP_HI_STRB = 3'd2;
    localparam t_step STEP_LO_SET  = 3'd3;
    localparam t_step STEP_LO_STRB = 3'd4;
    localparam t_step STEP_LO_END  = 3'd5;
    // Nibble-only request reuses step 3 as its closing state
    localparam t_step STEP_NIB_END = 3'd3;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_NIBBLE,
        KIND_ERROR
    } t_kind;

    typedef struct packed {
        t_kind   kind;
        logic    rs;
        t_nibble old_nib;
        t_nibble hi;
        t_nibble lo;
    } t_item;

    typedef struct packed {
        logic    rs_level;
        logic    enable_level;
        t_nibble bus_nibble;
        t_units  hold_units;
        logic    last;
        logic    error;
    } t_pin;

endpackage

/* rtl/cl4_in_if.sv */
// Request channel of the LCD write sequencer: valid/ready plus request fields.
// Depends on cl4_pkg.
interface cl4_in_if import cl4_pkg::*; ();
    logic    valid;
    logic    ready;
    t_cmd    cmd;
    t_byte   value;
    logic [1:0] row;
    t_nibble column;

    modport source (output valid, output cmd, output value, output row, output column,
                    input ready);
    modport sink   (input valid, input cmd, input value, input row, input column,
                    output ready);
endinterface

/* rtl/cl4_out_if.sv */
// Pin-state channel of the LCD write sequencer: valid/ready plus pin fields.
// Depends on cl4_pkg.
interface cl4_out_if import cl4_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    rs_level;
    logic    enable_level;
    t_nibble bus_nibble;
    t_units  hold_units;
    logic    last;
    logic    error;

    modport source (output valid, output rs_level, output enable_level, output bus_nibble,
                    output hold_units, output last, output error, input ready);
    modport sink   (input valid, input rs_level, input enable_level, input bus_nibble,
                    input hold_units, input last, input error, output ready);
endinterface

/* rtl/cl4_step_gen.sv */
// Pin-state generator: maps a decoded request and a step index to one pin word.
// Depends on cl4_pkg.
module cl4_step_gen import cl4_pkg::*; (
    input  t_item  i_item,
    input  t_step  i_step,
    input  t_units i_first_pulse,
    output t_pin   o_pin
);

    always_comb begin
        o_pin              = '0;
        o_pin.rs_level     = i_item.rs;
        o_pin.bus_nibble   = i_item.old_nib;
        o_pin.hold_units   = HOLD_ONE;
        unique case (i_item.kind)
            KIND_BYTE: begin
                unique case (i_step)
                    STEP_OLD: begin
                        o_pin.bus_nibble = i_item.old_nib;
                    end
                    STEP_HI_SET: begin
                        o_pin.bus_nibble = i_item.hi;
                    end
                    STEP_HI_STRB: begin
                        o_pin.bus_nibble   = i_item.hi;
                        o_pin.enable_level = 1'b1;
                    end
                    STEP_LO_SET: begin
                        o_pin.bus_nibble = i_item.lo;
                    end
                    STEP_LO_STRB: begin
                        o_pin.bus_nibble   = i_item.lo;
                        o_pin.enable_level = 1'b1;
                    end
                    STEP_LO_END: begin
                        o_pin.bus_nibble = i_item.lo;
                        o_pin.last       = 1'b1;
                    end
                    default: begin
                        o_pin.last = 1'b1;
                    end
                endcase
            end
            KIND_NIBBLE: begin
                unique case (i_step)
                    STEP_OLD: begin
                        o_pin.bus_nibble = i_item.old_nib;
                    end
                    STEP_HI_SET: begin
                        o_pin.bus_nibble = i_item.hi;
                        o_pin.hold_units = HOLD_ZERO;
                    end
                    STEP_HI_STRB: begin
                        o_pin.bus_nibble   = i_item.hi;
                        o_pin.enable_level = 1'b1;
                        o_pin.hold_units   = i_first_pulse;
                    end
                    STEP_NIB_END: begin
                        o_pin.bus_nibble = i_item.hi;
                        o_pin.hold_units = HOLD_ZERO;
                        o_pin.last       = 1'b1;
                    end
                    default: begin
                        o_pin.last = 1'b1;
                    end
                endcase
            end
            KIND_ERROR: begin
                o_pin.hold_units = HOLD_ZERO;
                o_pin.last       = 1'b1;
                o_pin.error      = 1'b1;
            end
            default: begin
                o_pin.last = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/char_lcd_4bit_write_sequencer.sv */
// Top level of the character LCD 4-bit write sequencer.
// Depends on cl4_pkg, cl4_in_if, cl4_out_if and cl4_step_gen.
//
//   channel   dir  word                                   handshake
//   i_req     in   cmd, value, row, column                valid/ready
//   o_pin     out  rs, E, DB7..DB4, hold, last, error     valid/ready
//   i_cfg_*   in   first_pulse_units (5 bits)             write enable, no wait
//
// A request is decoded in the cycle it is accepted and held in the request
// register; one pin word per cycle then moves into the output register while
// that register is empty or its word is taken. A request gives 6 pin words
// (byte or cursor), 4 (nibble-only) or 1 (bad row); the next request is taken in
// the cycle its predecessor's last word moves out, so there is no gap.
// Reset clears the valid flags, the bus levels left behind and sets the pulse
// register to 20. A stalled output holds its word and the request register.
module char_lcd_4bit_write_sequencer import cl4_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  t_units          i_cfg_data,
    cl4_in_if.sink          i_req,
    cl4_out_if.source       o_pin
);

    // Configuration register
    t_units  r_first_pulse;

    // Bus levels left by the last request
    t_nibble r_drv_nib;
    logic    r_drv_rs;

    // Request register
    logic    r_item_valid;
    t_item   r_item;
    t_step   r_step;

    // Output register
    logic    r_out_valid;
    t_pin    r_out;

    t_pin    step_pin;
    logic    advance;
    logic    item_done;
    logic    accept;
    t_item   n_item;
    t_byte   send_byte;
    t_byte   cursor_addr;
    t_nibble n_drv_nib;
    logic    n_drv_rs;

    cl4_step_gen u_step_gen (
        .i_item        (r_item),
        .i_step        (r_step),
        .i_first_pulse (r_first_pulse),
        .o_pin         (step_pin)
    );

    // Move a word into the output register when it is empty or being taken
    assign advance   = r_item_valid && (!r_out_valid || o_pin.ready);
    assign item_done = advance && step_pin.last;
    assign i_req.ready = !r_item_valid || item_done;
    assign accept    = i_req.valid && i_req.ready;

    // Decode the incoming request against the current bus levels
    always_comb begin
        cursor_addr = (i_req.row == ROW_UPPER) ? DDRAM_UPPER_BASE : DDRAM_LOWER_BASE;
        if (i_req.column < COLUMN_LIMIT) begin
            cursor_addr = cursor_addr + {4'd0, i_req.column};
        end
        send_byte = (i_req.cmd == CMD_SET_CURSOR) ? cursor_addr : i_req.value;

        n_item.kind    = KIND_BYTE;
        n_item.rs      = 1'b0;
        n_item.old_nib = r_drv_nib;
        n_item.hi      = send_byte[7:4];
        n_item.lo      = send_byte[3:0];
        n_drv_nib      = r_drv_nib;
        n_drv_rs       = r_drv_rs;

        unique case (i_req.cmd)
            CMD_INSTR: begin
                n_drv_nib = send_byte[3:0];
                n_drv_rs  = 1'b0;
            end
            CMD_DATA: begin
                n_item.rs = 1'b1;
                n_drv_nib = send_byte[3:0];
                n_drv_rs  = 1'b1;
            end
            CMD_FIRST_NIB: begin
                n_item.kind = KIND_NIBBLE;
                n_drv_nib   = send_byte[7:4];
                n_drv_rs    = 1'b0;
            end
            CMD_SET_CURSOR: begin
                if (i_req.row == ROW_UPPER || i_req.row == ROW_LOWER) begin
                    n_drv_nib = send_byte[3:0];
                    n_drv_rs  = 1'b0;
                end else begin
                    // bad row: report once, leave the bus levels alone
                    n_item.kind = KIND_ERROR;
                    n_item.rs   = r_drv_rs;
                end
            end
            default: begin
                n_item.kind = KIND_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_pulse <= FIRST_PULSE_RESET;
            r_drv_nib     <= '0;
            r_drv_rs      <= 1'b0;
            r_item_valid  <= 1'b0;
            r_step        <= STEP_OLD;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_first_pulse <= i_cfg_data;
            end

            // Request register: load on accept, drop after the last word
            if (accept) begin
                r_item_valid <= 1'b1;
                r_step       <= STEP_OLD;
                r_drv_nib    <= n_drv_nib;
                r_drv_rs     <= n_drv_rs;
            end else if (item_done) begin
                r_item_valid <= 1'b0;
                r_step       <= STEP_OLD;
            end else if (advance) begin
                r_step <= r_step + 3'd1;
            end

            // Output register valid
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_pin.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
        if (advance) begin
            r_out <= step_pin;
        end
    end

    assign o_pin.valid        = r_out_valid;
    assign o_pin.rs_level     = r_out.rs_level;
    assign o_pin.enable_level = r_out.enable_level;
    assign o_pin.bus_nibble   = r_out.bus_nibble;
    assign o_pin.hold_units   = r_out.hold_units;
    assign o_pin.last         = r_out.last;
    assign o_pin.error        = r_out.error;

endmodule

/* tb/char_lcd_4bit_write_sequencer_tb.sv */
// Self-checking testbench for the character LCD 4-bit write sequencer.
// Drives requests and pulse-length writes, predicts every pin word and checks them in order.
// Depends on cl4_pkg, cl4_in_if, cl4_out_if and char_lcd_4bit_write_sequencer.
module char_lcd_4bit_write_sequencer_tb;
    import cl4_pkg::*;

    // One request, plus an optional hand-typed final pin word that replaces
    // the predicted one for rows whose outcome is obvious.
    typedef struct packed {
        t_cmd       cmd;
        t_byte      value;
        logic [1:0] row;
        t_nibble    column;
        logic       typed;
        t_pin       typed_last;
    } t_lcd_req;

    localparam int N_DIRECTED = 21;
    localparam int N_PHASE_ITEMS = 72;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int DRAIN_CYCLES = 8;

    // Directed rows, starting from the reset bus levels (nibble 0, RS 0) and
    // the reset pulse length of 20 units.
    localparam t_lcd_req DIRECTED [N_DIRECTED] = '{
        // plain instruction right after reset
        '{CMD_INSTR,      8'h28, 2'd0, 4'd0, 1'b1, '{1'b0, 1'b0, 4'h8, HOLD_ONE,  1'b1, 1'b0}},
        // invalid rows keep the levels left by the previous request
        '{CMD_SET_CURSOR, 8'h00, 2'd2, 4'd0, 1'b1, '{1'b0, 1'b0, 4'h8, HOLD_ZERO, 1'b1, 1'b1}},
        '{CMD_DATA,       8'hFF, 2'd0, 4'd0, 1'b1, '{1'b1, 1'b0, 4'hF, HOLD_ONE,  1'b1, 1'b0}},
        '{CMD_SET_CURSOR, 8'hFF, 2'd3, 4'hF, 1'b1, '{1'b1, 1'b0, 4'hF, HOLD_ZERO, 1'b1, 1'b1}},
        '{CMD_DATA,       8'h00, 2'd3, 4'hF, 1'b1, '{1'b1, 1'b0, 4'h0, HOLD_ONE,  1'b1, 1'b0}},
        // nibble-only set-up instruction
        '{CMD_FIRST_NIB,  8'h30, 2'd0, 4'd0, 1'b1, '{1'b0, 1'b0, 4'h3, HOLD_ZERO, 1'b1, 1'b0}},
        '{CMD_FIRST_NIB,  8'hFF, 2'd3, 4'hF, 1'b0, '0},
        '{CMD_FIRST_NIB,  8'h00, 2'd0, 4'd0, 1'b0, '0},
        // upper row: column added below 8, dropped at 8 and above
        '{CMD_SET_CURSOR, 8'h00, 2'd1, 4'd0, 1'b1, '{1'b0, 1'b0, 4'h0, HOLD_ONE,  1'b1, 1'b0}},
        '{CMD_SET_CURSOR, 8'h00, 2'd1, 4'd7, 1'b1, '{1'b0, 1'b0, 4'h7, HOLD_ONE,  1'b1, 1'b0}},
        '{CMD_SET_CURSOR, 8'h00, 2'd1, 4'd8, 1'b1, '{1'b0, 1'b0, 4'h0, HOLD_ONE,  1'b1, 1'b0}},
        // lower row
        '{CMD_SET_CURSOR, 8'hFF, 2'd0, 4'hF, 1'b1, '{1'b0, 1'b0, 4'h0, HOLD_ONE,  1'b1, 1'b0}},
        '{CMD_SET_CURSOR, 8'h00, 2'd0, 4'd5, 1'b0, '0},
        '{CMD_SET_CURSOR, 8'h00, 2'd0, 4'd0, 1'b0, '0},
        '{CMD_INSTR,      8'hFF, 2'd0, 4'd0, 1'b0, '0},
        '{CMD_INSTR,      8'h00, 2'd0, 4'd0, 1'b0, '0},
        '{CMD_DATA,       8'hA5, 2'd3, 4'hF, 1'b0, '0},
        '{CMD_DATA,       8'h5A, 2'd0, 4'd0, 1'b0, '0},
        // bad row right after data: RS stays high on the error word
        '{CMD_SET_CURSOR, 8'h00, 2'd2, 4'd9, 1'b0, '0},
        '{CMD_FIRST_NIB,  8'h81, 2'd1, 4'd7, 1'b0, '0},
        '{CMD_INSTR,      8'h01, 2'd0, 4'd0, 1'b0, '0}
    };

    logic   i_clk;
    logic   i_rst_n;
    logic   i_cfg_we;
    t_units i_cfg_data;

    cl4_in_if  req_if ();
    cl4_out_if pin_if ();

    char_lcd_4bit_write_sequencer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_pin      (pin_if.source)
    );

    // Predictor state: bus levels left behind and the pulse length in force
    t_nibble bus_nib_left;
    logic    bus_rs_left;
    t_units  pulse_units;

    t_pin     pins_due [$];
    t_lcd_req req_backlog [$];
    t_lcd_req on_bus;

    int unsigned fail_count;
    int unsigned send_gap_left;
    int unsigned recv_idle_left;
    int unsigned hold_off_left;
    bit          hold_off_req;
    bit          quiet;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic push_pin(input logic rs, input logic en, input t_nibble nib,
                            input t_units hold, input logic fin, input logic err);
        t_pin w;
        w.rs_level     = rs;
        w.enable_level = en;
        w.bus_nibble   = nib;
        w.hold_units   = hold;
        w.last         = fin;
        w.error        = err;
        pins_due.push_back(w);
    endtask

    // High nibble then low nibble, each strobed by a one-unit E pulse
    task automatic pin_byte_words(input logic rs, input t_byte b);
        push_pin(rs, 1'b0, bus_nib_left, HOLD_ONE, 1'b0, 1'b0);
        push_pin(rs, 1'b0, b[7:4], HOLD_ONE, 1'b0, 1'b0);
        push_pin(rs, 1'b1, b[7:4], HOLD_ONE, 1'b0, 1'b0);
        push_pin(rs, 1'b0, b[3:0], HOLD_ONE, 1'b0, 1'b0);
        push_pin(rs, 1'b1, b[3:0], HOLD_ONE, 1'b0, 1'b0);
        push_pin(rs, 1'b0, b[3:0], HOLD_ONE, 1'b1, 1'b0);
        bus_nib_left = b[3:0];
        bus_rs_left  = rs;
    endtask

    // Work out every pin word one accepted request causes
    task automatic sequence_pins(input t_lcd_req r);
        t_byte addr;
        if (r.cmd == CMD_INSTR) begin
            pin_byte_words(1'b0, r.value);
        end else if (r.cmd == CMD_DATA) begin
            pin_byte_words(1'b1, r.value);
        end else if (r.cmd == CMD_FIRST_NIB) begin
            push_pin(1'b0, 1'b0, bus_nib_left, HOLD_ONE, 1'b0, 1'b0);
            push_pin(1'b0, 1'b0, r.value[7:4], HOLD_ZERO, 1'b0, 1'b0);
            push_pin(1'b0, 1'b1, r.value[7:4], pulse_units, 1'b0, 1'b0);
            push_pin(1'b0, 1'b0, r.value[7:4], HOLD_ZERO, 1'b1, 1'b0);
            bus_nib_left = r.value[7:4];
            bus_rs_left  = 1'b0;
        end else if (r.row == ROW_UPPER || r.row == ROW_LOWER) begin
            addr = (r.row == ROW_UPPER) ? DDRAM_UPPER_BASE : DDRAM_LOWER_BASE;
            if (r.column < COLUMN_LIMIT) addr = addr + {4'd0, r.column};
            pin_byte_words(1'b0, addr);
        end else begin
            // bad row: one error word, bus levels untouched
            push_pin(bus_rs_left, 1'b0, bus_nib_left, HOLD_ZERO, 1'b1, 1'b1);
        end
    endtask

    task automatic check_field(input string name, input logic [4:0] want,
                               input logic [4:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Request driver: advance to the next word only once the current one is
    // taken, insert random gaps, and predict at the edge of acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                sequence_pins(on_bus);
                if (on_bus.typed) pins_due[pins_due.size() - 1] = on_bus.typed_last;
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap_left > 0) begin
                    send_gap_left--;
                    req_if.valid <= 1'b0;
                end else if (req_backlog.size() == 0) begin
                    req_if.valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 3) == 0) begin
                    send_gap_left = $urandom_range(1, 8) - 1;
                    req_if.valid <= 1'b0;
                end else begin
                    on_bus = req_backlog.pop_front();
                    req_if.cmd    <= on_bus.cmd;
                    req_if.value  <= on_bus.value;
                    req_if.row    <= on_bus.row;
                    req_if.column <= on_bus.column;
                    req_if.valid  <= 1'b1;
                end
            end
        end
    end

    // Pin receiver: random idle bursts, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            pin_if.ready <= 1'b0;
        end else if (hold_off_req) begin
            hold_off_req  = 1'b0;
            hold_off_left = HOLD_OFF_CYCLES - 1;
            pin_if.ready <= 1'b0;
        end else if (quiet) begin
            pin_if.ready <= 1'b1;
        end else if (recv_idle_left > 0) begin
            recv_idle_left--;
            pin_if.ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            recv_idle_left = $urandom_range(1, 8) - 1;
            pin_if.ready <= 1'b0;
        end else begin
            pin_if.ready <= 1'b1;
        end
    end

    // Compare each taken pin word with the oldest prediction
    always @(posedge i_clk) begin : check_pins
        t_pin due;
        if (i_rst_n && pin_if.valid && pin_if.ready) begin
            if (pins_due.size() == 0) begin
                $error("pin word with no request outstanding");
                fail_count++;
            end else begin
                due = pins_due.pop_front();
                check_field("rs_level", 5'(due.rs_level), 5'(pin_if.rs_level));
                check_field("enable_level", 5'(due.enable_level),
                            5'(pin_if.enable_level));
                check_field("bus_nibble", 5'(due.bus_nibble), 5'(pin_if.bus_nibble));
                check_field("hold_units", due.hold_units, pin_if.hold_units);
                check_field("last", 5'(due.last), 5'(pin_if.last));
                check_field("error", 5'(due.error), 5'(pin_if.error));
            end
        end
    end

    // Hold until every request is taken and every pin word has come out
    task automatic drain;
        while (req_backlog.size() != 0 || req_if.valid || pins_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the pulse length while idle, then queue a batch of random requests
    task automatic run_phase(input t_units pulse, input bit long_stall);
        t_lcd_req r;
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= pulse;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        pulse_units = pulse;
        if (long_stall) hold_off_req = 1'b1;
        for (int i = 0; i < N_PHASE_ITEMS; i++) begin
            r.cmd    = t_cmd'($urandom_range(0, 3));
            r.value  = t_byte'($urandom_range(0, 255));
            // mostly valid rows so cursor requests reach the address path
            r.row    = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(2, 3))
                                                   : 2'($urandom_range(0, 1));
            r.column = t_nibble'($urandom_range(0, 15));
            r.typed  = 1'b0;
            r.typed_last = '0;
            req_backlog.push_back(r);
        end
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = FIRST_PULSE_RESET;
        req_if.valid  = 1'b0;
        req_if.cmd    = CMD_INSTR;
        req_if.value  = '0;
        req_if.row    = ROW_LOWER;
        req_if.column = '0;
        pin_if.ready  = 1'b0;
        bus_nib_left  = '0;
        bus_rs_left   = 1'b0;
        pulse_units   = FIRST_PULSE_RESET;
        fail_count    = 0;
        send_gap_left = 0;
        recv_idle_left = 0;
        hold_off_left = 0;
        hold_off_req  = 1'b0;
        quiet         = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows run on the reset pulse length
        for (int i = 0; i < N_DIRECTED; i++) req_backlog.push_back(DIRECTED[i]);
        drain();

        run_phase(5'd31, 1'b0);
        run_phase(5'd0, 1'b1);
        run_phase(5'd1, 1'b0);
        run_phase(t_units'($urandom_range(2, 30)), 1'b0);
        // last stretch with no idling on either side
        quiet = 1'b1;
        run_phase(5'd17, 1'b0);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
